// ===== hdl/ihex_pkg.sv =====
// Shared types, constants and microcode for the Intel HEX record encoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ihex_pkg;

  localparam int RECORD_BYTES_DEF = 32;
  localparam logic [15:0] SEG_BASE_RST = 16'h6000;

  // ASCII characters of the record text
  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_0     = 7'h30;
  localparam logic [6:0] CH_1     = 7'h31;
  localparam logic [6:0] CH_2     = 7'h32;
  localparam logic [6:0] CH_4     = 7'h34;
  localparam logic [6:0] CH_9     = 7'h39;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_F     = 7'h46;
  localparam logic [6:0] HEX_ALPHA_BASE = 7'h37;  // 'A' - 10

  // Microcode addressing
  localparam int STEP_W = 6;
  localparam int NSTEP  = 42;
  localparam logic [STEP_W-1:0] S_START = 6'd0;   // ':' of the first record
  localparam logic [STEP_W-1:0] S_DATA  = 6'd17;  // count digits of the data record
  localparam logic [STEP_W-1:0] S_DHI   = 6'd25;  // data byte loop
  localparam logic [STEP_W-1:0] S_END   = 6'd30;  // end record

  // Which nibble a hex step prints
  typedef enum logic [3:0] {
    N_SEG3, N_SEG2, N_SEG1, N_SEG0,
    N_AK1,  N_AK0,
    N_CNT1, N_CNT0,
    N_OFF3, N_OFF2, N_OFF1, N_OFF0,
    N_DAT1, N_DAT0,
    N_DK1,  N_DK0
  } nib_e;

  typedef enum logic [1:0] {
    J_NONE,
    J_NOADDR,  // skip the address record when the upper half is current
    J_MORE     // loop while data bytes remain
  } jmp_e;

  typedef enum logic [2:0] {
    A_NONE,
    A_ADDR,    // latch the announced upper half
    A_COMMIT,  // data record done: advance offset, empty the store
    A_INC,     // next data byte
    A_CLEAR    // end record done: back to reset state, segment base kept
  } act_e;

  typedef struct packed {
    logic              hex;
    nib_e              nib;
    logic [6:0]        lit;
    jmp_e              jmp;
    logic [STEP_W-1:0] tgt;
    act_e              act;
  } ucode_t;

  typedef struct packed {
    logic   adv;    // sequencer executes the current word this cycle
    logic   wr;     // store an incoming byte
    logic   last;   // current character closes the request's text
    ucode_t uw;
  } seq_ctl_t;

  typedef struct packed {
    logic need_addr;
    logic more;
    logic fill_zero;
    logic fill_last;
  } dp_stat_t;

  function automatic ucode_t uc(input logic hx, input nib_e n, input logic [6:0] c,
                                input jmp_e j, input logic [STEP_W-1:0] t, input act_e a);
    ucode_t w;
    w.hex = hx;
    w.nib = n;
    w.lit = c;
    w.jmp = j;
    w.tgt = t;
    w.act = a;
    return w;
  endfunction

  function automatic ucode_t lit_w(input logic [6:0] c);
    return uc(1'b0, N_SEG3, c, J_NONE, S_START, A_NONE);
  endfunction

  function automatic ucode_t hex_w(input nib_e n);
    return uc(1'b1, n, CH_0, J_NONE, S_START, A_NONE);
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (CH_0 + 7'(n)) : (HEX_ALPHA_BASE + 7'(n));
  endfunction

  // One character per step:
  //   ":02000004SSSSKK\n" (optional), ":CCHHLL00{DD}KK\n", ":00000001FF\n"
  localparam ucode_t UCODE [NSTEP] = '{
    uc(1'b0, N_SEG3, CH_COLON, J_NOADDR, S_DATA, A_NONE),
    lit_w(CH_0), lit_w(CH_2),
    lit_w(CH_0), lit_w(CH_0), lit_w(CH_0), lit_w(CH_0), lit_w(CH_0),
    lit_w(CH_4),
    hex_w(N_SEG3), hex_w(N_SEG2), hex_w(N_SEG1), hex_w(N_SEG0),
    hex_w(N_AK1), hex_w(N_AK0),
    uc(1'b0, N_SEG3, CH_LF, J_NONE, S_START, A_ADDR),
    lit_w(CH_COLON),
    hex_w(N_CNT1), hex_w(N_CNT0),
    hex_w(N_OFF3), hex_w(N_OFF2), hex_w(N_OFF1), hex_w(N_OFF0),
    lit_w(CH_0), lit_w(CH_0),
    hex_w(N_DAT1),
    uc(1'b1, N_DAT0, CH_0, J_MORE, S_DHI, A_INC),
    hex_w(N_DK1), hex_w(N_DK0),
    uc(1'b0, N_SEG3, CH_LF, J_NONE, S_START, A_COMMIT),
    lit_w(CH_COLON),
    lit_w(CH_0), lit_w(CH_0), lit_w(CH_0), lit_w(CH_0),
    lit_w(CH_0), lit_w(CH_0), lit_w(CH_0),
    lit_w(CH_1), lit_w(CH_F), lit_w(CH_F),
    uc(1'b0, N_SEG3, CH_LF, J_NONE, S_START, A_CLEAR)
  };

endpackage

// ===== hdl/ihex_useq.sv =====
// Microcode sequencer: step counter, control ROM, jumps and request intake.
// Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_useq import ihex_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     final_byte_i,
  input  logic     end_only_i,
  input  dp_stat_t stat_i,
  input  logic     stall_i,
  output seq_ctl_t ctl_o
);

  logic              busy_q, busy_d;
  logic              end_q, end_d;
  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            w;
  logic              acc, adv, fin, take;

  always_comb begin
    acc  = in_valid_i && !busy_q;
    adv  = busy_q && !stall_i;
    w    = UCODE[step_q];
    fin  = (w.act == A_CLEAR) || ((w.act == A_COMMIT) && !end_q);
    take = ((w.jmp == J_NOADDR) && !stat_i.need_addr) ||
           ((w.jmp == J_MORE) && stat_i.more);

    busy_d = busy_q;
    end_d  = end_q;
    step_d = step_q;
    if (acc) begin
      if (end_only_i) begin
        busy_d = 1'b1;
        end_d  = 1'b1;
        step_d = stat_i.fill_zero ? S_END : S_START;
      end else if (final_byte_i || stat_i.fill_last) begin
        busy_d = 1'b1;
        end_d  = final_byte_i;
        step_d = S_START;
      end
    end else if (adv) begin
      if (fin) begin
        busy_d = 1'b0;
      end else begin
        step_d = take ? w.tgt : step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      end_q  <= 1'b0;
      step_q <= S_START;
    end else begin
      busy_q <= busy_d;
      end_q  <= end_d;
      step_q <= step_d;
    end
  end

  assign in_ready_o = !busy_q;
  assign ctl_o.adv  = adv;
  assign ctl_o.wr   = acc && !end_only_i;
  assign ctl_o.last = fin;
  assign ctl_o.uw   = w;

endmodule

// ===== hdl/ihex_dpath.sv =====
// Datapath: record store memory, address and fill state, checksums and the
// character mux driven by the control word. Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_dpath import ihex_pkg::*; #(
  parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [7:0]  byte_value_i,
  input  seq_ctl_t    ctl_i,
  output dp_stat_t    stat_o,
  output logic [6:0]  char_o
);

  localparam int FILL_W = $clog2(RECORD_BYTES + 1);
  localparam int IDX_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  logic [7:0]        mem_q [RECORD_BYTES];
  logic [7:0]        rdata_q;
  logic [15:0]       seg_base_q;
  logic [31:0]       offset_q, offset_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [7:0]        sum_q, sum_d;
  logic [15:0]       upper_q, upper_d;
  logic              known_q, known_d;

  logic [15:0] seg;
  logic [7:0]  cnt, ak, dk;
  logic [3:0]  nib;

  always_comb begin
    offset_d = offset_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    upper_d  = upper_q;
    known_d  = known_q;
    if (ctl_i.wr) begin
      fill_d = fill_q + 1'b1;
      sum_d  = sum_q + byte_value_i;
    end
    if (ctl_i.adv) begin
      unique case (ctl_i.uw.act)
        A_NONE: ;
        A_ADDR: begin
          known_d = 1'b1;
          upper_d = offset_q[31:16];
        end
        A_COMMIT: begin
          offset_d = offset_q + 32'(fill_q);
          fill_d   = '0;
          idx_d    = '0;
          sum_d    = '0;
        end
        A_INC: idx_d = idx_q + 1'b1;
        A_CLEAR: begin
          offset_d = '0;
          fill_d   = '0;
          idx_d    = '0;
          sum_d    = '0;
          upper_d  = '0;
          known_d  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_base_q <= SEG_BASE_RST;
      offset_q   <= '0;
      fill_q     <= '0;
      idx_q      <= '0;
      sum_q      <= '0;
      upper_q    <= '0;
      known_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seg_base_q <= cfg_wdata_i;
      end
      offset_q <= offset_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      upper_q  <= upper_d;
      known_q  <= known_d;
    end
  end

  // Read follows the next index so rdata_q always holds the entry at idx_q.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[fill_q[IDX_W-1:0]] <= byte_value_i;
    end
    rdata_q <= mem_q[idx_d];
  end

  always_comb begin
    seg = offset_q[31:16] + seg_base_q;
    cnt = 8'(fill_q);
    ak  = 8'd0 - (8'd6 + seg[15:8] + seg[7:0]);
    dk  = 8'd0 - (cnt + offset_q[15:8] + offset_q[7:0] + sum_q);
    unique case (ctl_i.uw.nib)
      N_SEG3:  nib = seg[15:12];
      N_SEG2:  nib = seg[11:8];
      N_SEG1:  nib = seg[7:4];
      N_SEG0:  nib = seg[3:0];
      N_AK1:   nib = ak[7:4];
      N_AK0:   nib = ak[3:0];
      N_CNT1:  nib = cnt[7:4];
      N_CNT0:  nib = cnt[3:0];
      N_OFF3:  nib = offset_q[15:12];
      N_OFF2:  nib = offset_q[11:8];
      N_OFF1:  nib = offset_q[7:4];
      N_OFF0:  nib = offset_q[3:0];
      N_DAT1:  nib = rdata_q[7:4];
      N_DAT0:  nib = rdata_q[3:0];
      N_DK1:   nib = dk[7:4];
      N_DK0:   nib = dk[3:0];
      default: nib = '0;
    endcase
    char_o = ctl_i.uw.hex ? hex_char(nib) : ctl_i.uw.lit;
  end

  assign stat_o.need_addr = !known_q || (offset_q[31:16] != upper_q);
  assign stat_o.more      = (FILL_W'(idx_q) + FILL_W'(1)) != fill_q;
  assign stat_o.fill_zero = (fill_q == '0);
  assign stat_o.fill_last = (fill_q == FILL_W'(RECORD_BYTES - 1));

endmodule

// ===== hdl/ihex_pack.sv =====
// Pair packer: joins characters two by two into the output register.
// Depends on ihex_pkg for the file house style only.
`timescale 1ns / 1ps

module ihex_pack import ihex_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       emit_i,
  input  logic [6:0] char_i,
  input  logic       last_i,
  output logic       stall_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] first_char_o,
  output logic [6:0] second_char_o,
  output logic       run_last_o
);

  logic       have_q;
  logic [6:0] hold_q;
  logic       vld_q;
  logic [6:0] first_q, second_q;
  logic       last_q;

  // Hold the sequencer only when a pair would land on a full output register.
  assign stall_o = have_q && vld_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      if (vld_q && out_ready_i) begin
        vld_q <= 1'b0;
      end
      if (emit_i) begin
        have_q <= !have_q;
        if (have_q) begin
          vld_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      if (!have_q) begin
        hold_q <= char_i;
      end else begin
        first_q  <= hold_q;
        second_q <= char_i;
        last_q   <= last_i;
      end
    end
  end

  assign out_valid_o   = vld_q;
  assign first_char_o  = first_q;
  assign second_char_o = second_q;
  assign run_last_o    = last_q;

endmodule

// ===== hdl/intel_hex_record_encoder.sv =====
// Intel HEX record encoder top level: sequencer, datapath and pair packer.
// Depends on ihex_pkg, ihex_useq, ihex_dpath and ihex_pack.
`timescale 1ns / 1ps

// Bytes that do not complete a record are taken one per cycle and only
// stored. A request that fills the record, carries final_byte or end_only
// starts the microcode sequencer, which prints one character per cycle
// while the pair packer does not stall it, and takes the next request in
// the cycle after its last character has gone to the pair packer. The pair
// packer hands out two characters per result and stalls the sequencer only
// while its output register is held. The record store is a single-port-write,
// single-port-read memory; it needs no clearing pass after reset.
module intel_hex_record_encoder import ihex_pkg::*; #(
  parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        final_byte_i,
  input  logic        end_only_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  first_char_o,
  output logic [6:0]  second_char_o,
  output logic        run_last_o
);

  seq_ctl_t   ctl;
  dp_stat_t   stat;
  logic [6:0] ch;
  logic       stall;

  ihex_useq u_useq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .final_byte_i (final_byte_i),
    .end_only_i   (end_only_i),
    .stat_i       (stat),
    .stall_i      (stall),
    .ctl_o        (ctl)
  );

  ihex_dpath #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_value_i (byte_value_i),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .char_o       (ch)
  );

  ihex_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_i        (ctl.adv),
    .char_i        (ch),
    .last_i        (ctl.last),
    .stall_o       (stall),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .first_char_o  (first_char_o),
    .second_char_o (second_char_o),
    .run_last_o    (run_last_o)
  );

endmodule

// ===== hdl/ihex_chk.sv =====
// Port-level checker for the Intel HEX record encoder and its bind.
// Depends on ihex_pkg and intel_hex_record_encoder.
`timescale 1ns / 1ps

module ihex_chk import ihex_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] first_char_o,
  input logic [6:0] second_char_o,
  input logic       run_last_o
);

  logic start_q;  // next pair opens a new run of text

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      start_q <= run_last_o;
    end
  end

  function automatic logic legal(input logic [6:0] c);
    return (c == CH_COLON) || (c == CH_LF) ||
           ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A) && (c <= CH_F));
  endfunction

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_char_o) &&
    $stable(second_char_o) && $stable(run_last_o))
    else $error("output pair changed while stalled");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_q |-> first_char_o == CH_COLON)
    else $error("run does not open with a record mark");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_last_o |-> second_char_o == CH_LF)
    else $error("run does not close with a newline");

  a_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> legal(first_char_o) && legal(second_char_o))
    else $error("character outside the record alphabet");

endmodule

bind intel_hex_record_encoder ihex_chk u_ihex_chk (.*);

// ===== verif/tb_intel_hex_record_encoder.sv =====
// Self-checking testbench for the Intel HEX record encoder: predicts the text
// of every request and compares each character pair that leaves the block.
// Depends on ihex_pkg and intel_hex_record_encoder.
`timescale 1ns / 1ps

module tb_intel_hex_record_encoder;

  localparam int REC_BYTES = ihex_pkg::RECORD_BYTES_DEF;
  localparam logic [127:0] HEX_LUT = "0123456789ABCDEF";

  typedef struct packed {
    logic [6:0] first_ch;
    logic [6:0] second_ch;
    logic       closes_req;
  } char_pair_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  byte_value_i;
  logic        final_byte_i;
  logic        end_only_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [6:0]  first_char_o;
  logic [6:0]  second_char_o;
  logic        run_last_o;

  // Encoder state as the testbench sees it
  logic [15:0] m_seg_base;
  logic [31:0] m_offset;
  logic [7:0]  m_store [REC_BYTES];
  int          m_fill;
  logic [15:0] m_upper;
  logic        m_upper_valid;

  logic [6:0]  req_text [$];
  char_pair_t  pair_q [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_left;
  int req_count;
  int pairs_checked;
  int cfg_writes;
  int fail_count;

  intel_hex_record_encoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_value_i  (byte_value_i),
    .final_byte_i  (final_byte_i),
    .end_only_i    (end_only_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .first_char_o  (first_char_o),
    .second_char_o (second_char_o),
    .run_last_o    (run_last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic void put_text(input string s);
    byte c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      req_text.push_back(c[6:0]);
    end
  endfunction

  function automatic void put_hex(input logic [7:0] v);
    req_text.push_back(HEX_LUT[8 * (15 - int'(v[7:4])) +: 7]);
    req_text.push_back(HEX_LUT[8 * (15 - int'(v[3:0])) +: 7]);
  endfunction

  function automatic void clear_model();
    m_offset      = '0;
    m_fill        = 0;
    m_upper       = '0;
    m_upper_valid = 1'b0;
  endfunction

  function automatic void flush_record();
    logic [15:0] upper;
    logic [15:0] seg;
    logic [7:0]  sum;
    if (m_fill == 0) return;
    upper = m_offset[31:16];
    // announce the upper half when it is new to this stream
    if (!m_upper_valid || upper != m_upper) begin
      m_upper_valid = 1'b1;
      m_upper = upper;
      seg = upper + m_seg_base;
      sum = 8'd6 + seg[15:8] + seg[7:0];
      put_text(":02000004");
      put_hex(seg[15:8]);
      put_hex(seg[7:0]);
      put_hex(8'h00 - sum);
      put_text("\n");
    end
    sum = 8'(m_fill) + m_offset[15:8] + m_offset[7:0];
    put_text(":");
    put_hex(8'(m_fill));
    put_hex(m_offset[15:8]);
    put_hex(m_offset[7:0]);
    put_text("00");
    for (int i = 0; i < m_fill; i++) begin
      put_hex(m_store[i]);
      sum += m_store[i];
    end
    put_hex(8'h00 - sum);
    put_text("\n");
    m_offset += 32'(m_fill);
    m_fill = 0;
  endfunction

  // Work out the character pairs that one accepted request causes
  function automatic void encode_request(input logic [7:0] b, input logic fin,
                                         input logic eo);
    char_pair_t p;
    int         pairs;
    req_text.delete();
    if (!eo) begin
      if (m_fill < REC_BYTES) begin
        m_store[m_fill] = b;
        m_fill++;
      end
      if (m_fill >= REC_BYTES) flush_record();
    end
    if (eo || fin) begin
      flush_record();
      put_text(":00000001FF\n");
      clear_model();
    end
    pairs = req_text.size() / 2;
    for (int k = 0; k < pairs; k++) begin
      p.first_ch   = req_text[2 * k];
      p.second_ch  = req_text[2 * k + 1];
      p.closes_req = (k == pairs - 1);
      pair_q.push_back(p);
    end
  endfunction

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_pairs
    char_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pair_q.size() == 0) begin
        note_failure($sformatf("unexpected pair %h %h last=%0b",
                               first_char_o, second_char_o, run_last_o));
      end else begin
        want = pair_q.pop_front();
        pairs_checked++;
        if (want.first_ch !== first_char_o || want.second_ch !== second_char_o ||
            want.closes_req !== run_last_o) begin
          note_failure($sformatf("pair mismatch: expected %h %h last=%0b, got %h %h last=%0b",
                                 want.first_ch, want.second_ch, want.closes_req,
                                 first_char_o, second_char_o, run_last_o));
        end
      end
    end
  end

  // Called and returns at a falling edge; valid stays high for a following request
  task automatic send_request(input logic [7:0] b, input logic fin, input logic eo);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= b;
    final_byte_i <= fin;
    end_only_i   <= eo;
    do @(posedge clk_i); while (!in_ready_o);
    encode_request(b, fin, eo);
    req_count++;
    @(negedge clk_i);
  endtask

  // n_bytes random bytes; end on the last byte or with a separate end request
  task automatic send_stream(input int n_bytes, input bit end_on_byte);
    for (int i = 0; i < n_bytes; i++)
      send_request(8'($urandom_range(255)), end_on_byte && (i == n_bytes - 1), 1'b0);
    if (!end_on_byte || n_bytes == 0)
      send_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pair_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_segment_base(input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    m_seg_base = v;
    cfg_writes++;
  endtask

  task automatic test_directed_ends();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // end with nothing pending: end record only
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'hA5, 1'b0, 1'b0);
    // both flags: the byte is dropped
    send_request(8'h3C, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    wait_drained();
    write_segment_base(16'h0000);
    send_request(8'h5A, 1'b1, 1'b0);
    wait_drained();
    write_segment_base(16'hFFFF);
    send_request(8'h80, 1'b0, 1'b0);
    send_request(8'h7F, 1'b0, 1'b0);
    send_request(8'h01, 1'b0, 1'b1);
  endtask

  task automatic test_config_mid_record();
    send_request(8'h01, 1'b0, 1'b0);
    send_request(8'hFE, 1'b0, 1'b0);
    wait_drained();
    // the address record picks up the base in force at flush time
    write_segment_base(16'h1234);
    send_request(8'h02, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
    int start;
    int pick;
    int len;
    start = req_count;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (req_count - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_request(8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
      end else begin
        if (pick < 65) len = $urandom_range(8, 1);
        else if (pick < 90) len = $urandom_range(40, 28);
        else len = $urandom_range(70, 60);
        // keep the stream within what is left of this phase
        if (len > n_items - (req_count - start)) len = n_items - (req_count - start);
        send_stream(len, 1'($urandom_range(1)));
      end
    end
    send_request(8'($urandom_range(255)), 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // hold the receiver off long enough for the input to stall
    rx_hold_left = 300;
    send_stream(34, 1'b1);
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    byte_value_i  = '0;
    final_byte_i  = 1'b0;
    end_only_i    = 1'b0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    rx_hold_left  = 0;
    req_count     = 0;
    pairs_checked = 0;
    cfg_writes    = 0;
    fail_count    = 0;
    m_seg_base    = ihex_pkg::SEG_BASE_RST;
    clear_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_ends();
    test_config_mid_record();
    write_segment_base(16'($urandom_range(65535)));
    test_random_traffic(34, 57, 18);
    write_segment_base(16'h0000);
    test_random_traffic(57, 34, 18);
    write_segment_base(ihex_pkg::SEG_BASE_RST);
    test_random_traffic(0, 0, 18);
    test_output_backpressure();

    in_valid_i <= 1'b0;
    for (int k = 0; k < 20000 && pair_q.size() != 0; k++) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (pair_q.size() != 0)
      note_failure($sformatf("%0d pairs never arrived", pair_q.size()));

    $display("Sent %0d requests, checked %0d character pairs, wrote the segment base %0d times.",
             req_count, pairs_checked, cfg_writes);
    $display("Covered bare ends, both-flag ends, base changes, full records and output stall.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
